// ----- hw/rtl/binary_trie_min_xor_top_assert.svh -----
// Assertion macros for the binary trie minimum-xor block.
`ifndef BINARY_TRIE_MIN_XOR_TOP_ASSERT_SVH
`define BINARY_TRIE_MIN_XOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define BTMX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define BTMX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTMX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BTMX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/btmx_pkg.sv -----
// Shared types and command codes for the binary trie minimum-xor block.
package btmx_pkg;

  // Command codes as they arrive on the input stream.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Operation classes handed from the front to the back.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } btmx_op_e;

  // Head of the command queue as seen by the back.
  typedef struct packed {
    logic     valid;
    btmx_op_e op;
  } btmx_cmd_t;

endpackage

// ----- hw/rtl/btmx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module btmx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/btmx_front.sv -----
// Front end: accepts commands, classifies them and queues them for the walker.
module btmx_front import btmx_pkg::*; #(
  parameter int KEY_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_cmd_i,
  input  logic [KEY_BITS-1:0] in_key_i,
  input  logic                pop_i,
  output btmx_cmd_t           cmd_o,
  output logic [KEY_BITS-1:0] key_o
);

  btmx_op_e            op_mem_q  [2];
  logic [KEY_BITS-1:0] key_mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;
  logic                push, pop;
  btmx_op_e            in_op;

  always_comb begin
    unique case (in_cmd_i)
      CMD_INSERT: in_op = OP_INSERT;
      CMD_QUERY:  in_op = OP_QUERY;
      CMD_CLEAR:  in_op = OP_CLEAR;
      CMD_NONE:   in_op = OP_NOP;
      default:    in_op = OP_NOP;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem_q[wr_ptr_q]  <= in_op;
      key_mem_q[wr_ptr_q] <= in_key_i;
    end
  end

  assign cmd_o.valid = (count_q != 2'd0);
  assign cmd_o.op    = op_mem_q[rd_ptr_q];
  assign key_o       = key_mem_q[rd_ptr_q];

endmodule

// ----- hw/rtl/btmx_back.sv -----
// Back end: walks the trie one level per cycle, allocates nodes and holds the result.
module btmx_back import btmx_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  btmx_cmd_t                     cmd_i,
  input  logic [KEY_BITS-1:0]           key_i,
  output logic                          pop_o,
  output logic [$clog2(NODE_COUNT)-1:0] raddr_o,
  input  logic [$clog2(NODE_COUNT)-1:0] left_rdata_i,
  input  logic [$clog2(NODE_COUNT)-1:0] right_rdata_i,
  output logic                          left_we_o,
  output logic [$clog2(NODE_COUNT)-1:0] left_waddr_o,
  output logic [$clog2(NODE_COUNT)-1:0] left_wdata_o,
  output logic                          right_we_o,
  output logic [$clog2(NODE_COUNT)-1:0] right_waddr_o,
  output logic [$clog2(NODE_COUNT)-1:0] right_wdata_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [KEY_BITS-1:0]           out_xor_o,
  output logic                          out_empty_o,
  output logic                          out_full_o
);

  localparam int LINK_W = $clog2(NODE_COUNT);
  localparam int NF_W   = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam logic [NF_W-1:0]  FREE_LIMIT = NF_W'(NODE_COUNT - KEY_BITS);
  localparam logic [LVL_W-1:0] TOP_LEVEL  = LVL_W'(KEY_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  btmx_op_e            op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [LVL_W-1:0]    level_q, level_d;
  logic [LINK_W-1:0]   p_q, p_d;
  logic [KEY_BITS-1:0] sum_q, sum_d;
  logic                empty_q, empty_d, full_q, full_d;
  logic [NF_W-1:0]     next_free_q, next_free_d;
  logic [LINK_W-1:0]   root_l_q, root_l_d, root_r_q, root_r_d;
  logic                out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0] out_xor_q, out_xor_d;
  logic                out_empty_q, out_empty_d, out_full_q, out_full_d;

  logic [LINK_W-1:0] cur_l, cur_r, same, other, nf_link, child;
  logic              cur_bit, next_bit, last;

  assign cur_l    = (p_q == '0) ? root_l_q : left_rdata_i;
  assign cur_r    = (p_q == '0) ? root_r_q : right_rdata_i;
  assign cur_bit  = key_q[level_q];
  assign next_bit = (level_q == '0) ? 1'b0 : key_q[level_q - 1'b1];
  assign same     = cur_bit ? cur_r : cur_l;
  assign other    = cur_bit ? cur_l : cur_r;
  assign last     = (level_q == '0);
  assign nf_link  = next_free_q[LINK_W-1:0];
  // The path child of a new node is the node allocated right after it.
  assign child    = last ? '0 : LINK_W'(next_free_q + 1'b1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    level_d     = level_q;
    p_d         = p_q;
    sum_d       = sum_q;
    empty_d     = empty_q;
    full_d      = full_q;
    next_free_d = next_free_q;
    root_l_d    = root_l_q;
    root_r_d    = root_r_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_xor_d   = out_xor_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;
    pop_o         = 1'b0;
    left_we_o     = 1'b0;
    left_waddr_o  = p_q;
    left_wdata_o  = nf_link;
    right_we_o    = 1'b0;
    right_waddr_o = p_q;
    right_wdata_o = nf_link;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          pop_o   = 1'b1;
          op_d    = cmd_i.op;
          key_d   = key_i;
          level_d = TOP_LEVEL;
          p_d     = '0;
          sum_d   = '0;
          empty_d = 1'b0;
          full_d  = 1'b0;
          state_d = ST_DONE;
          unique case (cmd_i.op)
            OP_INSERT: begin
              if (next_free_q > FREE_LIMIT) begin
                full_d = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            OP_QUERY: begin
              if (root_l_q == '0 && root_r_q == '0) begin
                empty_d = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            OP_CLEAR: begin
              next_free_d = NF_W'(1);
              root_l_d    = '0;
              root_r_d    = '0;
            end
            OP_NOP: ;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (op_q == OP_QUERY) begin
          if (same != '0) begin
            p_d = same;
          end else begin
            sum_d = sum_q | (KEY_BITS'(1) << level_q);
            p_d   = other;
          end
          if (last || p_d == '0) begin
            state_d = ST_DONE;
          end else begin
            level_d = level_q - 1'b1;
          end
        end else if (same != '0) begin
          p_d = same;
          if (last) begin
            state_d = ST_DONE;
          end else begin
            level_d = level_q - 1'b1;
          end
        end else begin
          // First missing child: hook the next free node under the current one.
          if (p_q == '0) begin
            if (cur_bit) begin
              root_r_d = nf_link;
            end else begin
              root_l_d = nf_link;
            end
          end else begin
            left_we_o  = !cur_bit;
            right_we_o = cur_bit;
          end
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        // Each new node gets both links in one write; the rest of the path follows.
        left_we_o     = 1'b1;
        right_we_o    = 1'b1;
        left_waddr_o  = nf_link;
        right_waddr_o = nf_link;
        left_wdata_o  = next_bit ? '0 : child;
        right_wdata_o = next_bit ? child : '0;
        next_free_d   = next_free_q + 1'b1;
        if (last) begin
          state_d = ST_DONE;
        end else begin
          level_d = level_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_xor_d   = sum_q;
          out_empty_d = empty_q;
          out_full_d  = full_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_free_q <= NF_W'(1);
      root_l_q    <= '0;
      root_r_q    <= '0;
      out_valid_q <= 1'b0;
      p_q         <= '0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      root_l_q    <= root_l_d;
      root_r_q    <= root_r_d;
      out_valid_q <= out_valid_d;
      p_q         <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    level_q     <= level_d;
    sum_q       <= sum_d;
    empty_q     <= empty_d;
    full_q      <= full_d;
    out_xor_q   <= out_xor_d;
    out_empty_q <= out_empty_d;
    out_full_q  <= out_full_d;
  end

  // The read issued now returns the links of the node the walk stands on next.
  assign raddr_o     = p_d;
  assign out_valid_o = out_valid_q;
  assign out_xor_o   = out_xor_q;
  assign out_empty_o = out_empty_q;
  assign out_full_o  = out_full_q;

endmodule

// ----- hw/rtl/binary_trie_min_xor_top.sv -----
// Top level of the binary trie minimum-xor engine.
//
// The block keeps a binary trie of KEY_BITS-bit keys and answers, for a given
// key, the smallest xor against any stored key. Commands enter on the slave
// stream: tuser carries the command (insert, query, clear, or an unused code
// that does nothing) and tdata carries the key. Every accepted command gives
// exactly one transfer on the master stream: tdata carries the minimum xor,
// tuser carries the empty flag (bit 0) and the full flag (bit 1).
// With the queue and walker idle, a query takes the command, walks one trie
// level per cycle (set by the dependent link read of the node RAMs) and then
// loads the result. A new key adds a step for the link write that hooks its
// path, a stored key does not; a rejected insert, clear and the unused code go
// straight from taking the command to loading the result. Commands run one at
// a time, so the walker takes no new command until the last result is loaded.
// A two-entry queue in front of the walker keeps the slave side accepting
// while a command runs or while a result waits for the receiver.
// When the receiver stalls, the held result stays put, the walker finishes
// its next command and waits, and the queue fills before tready drops.
// Reset empties the trie (root links in flip-flops) and the queue; the node
// RAMs need no clearing pass, because every node is written when allocated.
module binary_trie_min_xor_top import btmx_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((KEY_BITS+7)/8)*8-1:0]   s_axis_tdata,   // key, zero fill
  input  logic [1:0]                      s_axis_tuser,   // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [((KEY_BITS+7)/8)*8-1:0]   m_axis_tdata,   // min_xor, zero fill
  output logic [1:0]                      m_axis_tuser    // empty_flag, full_flag
);

`include "binary_trie_min_xor_top_assert.svh"

  localparam int LINK_W = $clog2(NODE_COUNT);
  localparam int DATA_W = ((KEY_BITS + 7) / 8) * 8;

  btmx_cmd_t           cmd;
  logic [KEY_BITS-1:0] cmd_key;
  logic                cmd_pop;

  logic [LINK_W-1:0] raddr, left_rdata, right_rdata;
  logic              left_we, right_we;
  logic [LINK_W-1:0] left_waddr, left_wdata, right_waddr, right_wdata;

  logic [KEY_BITS-1:0] out_xor;
  logic                out_empty, out_full;

  // Front end: command classification and the queue to the walker.
  btmx_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_key_i   (s_axis_tdata[KEY_BITS-1:0]),
    .pop_i      (cmd_pop),
    .cmd_o      (cmd),
    .key_o      (cmd_key)
  );

  // Back end: trie walker, node allocator and output register.
  btmx_back #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .key_i         (cmd_key),
    .pop_o         (cmd_pop),
    .raddr_o       (raddr),
    .left_rdata_i  (left_rdata),
    .right_rdata_i (right_rdata),
    .left_we_o     (left_we),
    .left_waddr_o  (left_waddr),
    .left_wdata_o  (left_wdata),
    .right_we_o    (right_we),
    .right_waddr_o (right_waddr),
    .right_wdata_o (right_wdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_xor_o     (out_xor),
    .out_empty_o   (out_empty),
    .out_full_o    (out_full)
  );

  // Left and right child links of every pool node. Entry 0 (the root) lives
  // in flip-flops inside the walker so that clear needs no RAM writes.
  btmx_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODE_COUNT)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .raddr_i (raddr),
    .rdata_o (left_rdata)
  );

  btmx_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODE_COUNT)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (right_wdata),
    .raddr_i (raddr),
    .rdata_o (right_rdata)
  );

  assign m_axis_tdata = DATA_W'(out_xor);
  assign m_axis_tuser = {out_full, out_empty};

  // The root is never stored in the RAMs.
  `BTMX_ASSERT_IMP(a_no_root_write, clk_i, rst_ni,
    left_we || right_we,
    (!left_we || left_waddr != '0) && (!right_we || right_waddr != '0),
    "node RAM write to the root entry")
  // A result with a nonzero xor is a successful query and carries no flag.
  `BTMX_ASSERT_IMP(a_xor_no_flags, clk_i, rst_ni,
    m_axis_tvalid && out_xor != '0,
    !out_empty && !out_full,
    "nonzero xor reported together with a flag")
  // A full queue stays full until the walker takes its head.
  `BTMX_ASSERT_NXT(a_queue_holds, clk_i, rst_ni,
    !s_axis_tready && !cmd_pop,
    !s_axis_tready && cmd.valid,
    "command queue lost an entry")

endmodule
